>>> design/periodic_timer_queue_assert.svh
// ----------------------------------------------------------------------------
// periodic timer queue assertion macros
// shared concurrent assertion forms, clocked on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TIMER_QUEUE_ASSERT_SVH
`define PERIODIC_TIMER_QUEUE_ASSERT_SVH

// same-cycle implication
`define PTQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PTQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/ptq_pkg.sv
// ----------------------------------------------------------------------------
// ptq_pkg
// types and codes shared by the periodic timer queue modules
// ----------------------------------------------------------------------------
`default_nettype none

package ptq_pkg;

  localparam int IdW  = 31;
  localparam int CntW = 32;
  localparam int LcW  = 5;

  // request kinds
  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_TICK   = 2'd2;

  // result events
  localparam logic [2:0] EV_ADDED    = 3'd0;
  localparam logic [2:0] EV_FULL     = 3'd1;
  localparam logic [2:0] EV_REMOVED  = 3'd2;
  localparam logic [2:0] EV_NOTFOUND = 3'd3;
  localparam logic [2:0] EV_FIRED    = 3'd4;

  typedef struct packed {
    logic [1:0]      kind;
    logic [CntW-1:0] period_ticks;
    logic            repeat_req;
    logic [IdW-1:0]  timer_id;
  } in_t;

  typedef struct packed {
    logic [2:0]     event_res;
    logic [IdW-1:0] result_id;
    logic [LcW-1:0] live_count;
    logic           last;
  } out_t;

  // one timer slot
  typedef struct packed {
    logic            valid;
    logic [IdW-1:0]  id;
    logic [CntW-1:0] remaining;
    logic [CntW-1:0] period;
    logic            rpt;
  } entry_t;

  // request as seen by the head cell
  typedef struct packed {
    logic [1:0]      kind;
    logic [CntW-1:0] period;
    logic            rpt;
    logic [IdW-1:0]  rid;
    logic [IdW-1:0]  id_new;
  } cmd_t;

  // head cell status back to control
  typedef struct packed {
    logic           found;
    logic           fire;
    logic [IdW-1:0] fire_id;
  } head_res_t;

endpackage

`default_nettype wire

>>> design/ptq_cell.sv
// ----------------------------------------------------------------------------
// ptq_cell
// one slot of the timer ring, takes its neighbor's entry on each shift
// ----------------------------------------------------------------------------
`default_nettype none

module ptq_cell (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   shift_i,
  input  wire ptq_pkg::entry_t  entry_i,
  output ptq_pkg::entry_t       entry_o
);

  logic                       valid_q;
  logic [ptq_pkg::IdW-1:0]    id_q;
  logic [ptq_pkg::CntW-1:0]   rem_q;
  logic [ptq_pkg::CntW-1:0]   per_q;
  logic                       rpt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= entry_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      id_q  <= entry_i.id;
      rem_q <= entry_i.remaining;
      per_q <= entry_i.period;
      rpt_q <= entry_i.rpt;
    end
  end

  assign entry_o = '{valid: valid_q, id: id_q, remaining: rem_q, period: per_q, rpt: rpt_q};

endmodule

`default_nettype wire

>>> design/ptq_head.sv
// ----------------------------------------------------------------------------
// ptq_head
// update of the slot passing the head of the ring for add, remove and tick
// ----------------------------------------------------------------------------
`default_nettype none

module ptq_head #(
  parameter int LW = 5
) (
  input  wire ptq_pkg::entry_t  entry_i,
  input  wire ptq_pkg::cmd_t    cmd_i,
  input  wire                   found_i,
  input  wire [LW-1:0]          live_i,
  output ptq_pkg::entry_t       entry_o,
  output logic [LW-1:0]         live_o,
  output ptq_pkg::head_res_t    res_o
);

  logic [ptq_pkg::CntW-1:0] rem_dec;

  assign rem_dec = entry_i.remaining - ptq_pkg::CntW'(1);

  always_comb begin
    entry_o       = entry_i;
    live_o        = live_i;
    res_o.found   = found_i;
    res_o.fire    = 1'b0;
    res_o.fire_id = entry_i.id;
    unique case (cmd_i.kind)
      ptq_pkg::KIND_ADD: begin
        // lowest free slot takes the new timer
        if (!found_i && !entry_i.valid) begin
          entry_o     = '{valid: 1'b1, id: cmd_i.id_new, remaining: cmd_i.period,
                          period: cmd_i.period, rpt: cmd_i.rpt};
          live_o      = live_i + LW'(1);
          res_o.found = 1'b1;
        end
      end
      ptq_pkg::KIND_REMOVE: begin
        if (!found_i && entry_i.valid && entry_i.id == cmd_i.rid) begin
          entry_o.valid = 1'b0;
          live_o        = live_i - LW'(1);
          res_o.found   = 1'b1;
        end
      end
      ptq_pkg::KIND_TICK: begin
        if (entry_i.valid) begin
          entry_o.remaining = rem_dec;
          if (rem_dec == '0) begin
            res_o.fire = 1'b1;
            if (entry_i.rpt) begin
              entry_o.remaining = entry_i.period;
            end else begin
              entry_o.valid = 1'b0;
              live_o        = live_i - LW'(1);
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

>>> design/periodic_timer_queue.sv
// ----------------------------------------------------------------------------
// periodic_timer_queue
// table of software timers held in a rotating ring of slot cells
// ----------------------------------------------------------------------------
//   channel | signals                          | payload
//   request | in_valid_i, in_stall_o          | in_req_i  (ptq_pkg::in_t)
//   result  | out_valid_o, out_stall_i        | out_res_o (ptq_pkg::out_t)
//
// a request is taken in an idle cycle, then the ring rotates once through all NUM_SLOTS
// slots so every slot passes the head cell in ascending order, then the ST_FIN state
// issues the final result, if the request has one.
// a new request is taken only after the previous one has finished.
// a stalled result register holds the rotation whenever another result must go out.
// reset clears all slot valid bits, the id counter and the live count at once.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_timer_queue #(
  parameter int NUM_SLOTS = 16
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  wire ptq_pkg::in_t   in_req_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output ptq_pkg::out_t       out_res_o
);

  localparam int LW = $clog2(NUM_SLOTS + 1);
  localparam int SW = $clog2(NUM_SLOTS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_STEP = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]              state_q, state_d;
  logic [SW-1:0]           step_q, step_d;
  logic                    found_q, found_d;
  logic [LW-1:0]           live_q, live_d;
  logic [ptq_pkg::IdW-1:0] idc_q, idc_d;
  ptq_pkg::cmd_t           cmd_q, cmd_d;
  logic                    pend_valid_q, pend_valid_d;
  ptq_pkg::out_t           pend_q, pend_d;
  logic                    out_valid_q, out_valid_d;
  ptq_pkg::out_t           out_q, out_d;

  ptq_pkg::entry_t         ring [NUM_SLOTS];
  ptq_pkg::entry_t         head_entry;
  logic [LW-1:0]           head_live;
  ptq_pkg::head_res_t      head_res;

  logic                    shift;
  logic                    out_free;
  logic                    step_emit;
  logic                    fin_emit;
  ptq_pkg::out_t           fin_res;
  logic [ptq_pkg::IdW-1:0] id_inc;
  logic [ptq_pkg::IdW-1:0] id_next;

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    if (i == NUM_SLOTS - 1) begin : g_tail
      ptq_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (shift),
        .entry_i (head_entry),
        .entry_o (ring[i])
      );
    end else begin : g_body
      ptq_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (shift),
        .entry_i (ring[i+1]),
        .entry_o (ring[i])
      );
    end
  end

  ptq_head #(.LW(LW)) u_head (
    .entry_i (ring[0]),
    .cmd_i   (cmd_q),
    .found_i (found_q),
    .live_i  (live_q),
    .entry_o (head_entry),
    .live_o  (head_live),
    .res_o   (head_res)
  );

  // id counter skips zero on wrap
  assign id_inc  = idc_q + ptq_pkg::IdW'(1);
  assign id_next = (id_inc == '0) ? ptq_pkg::IdW'(1) : id_inc;

  assign out_free  = !out_valid_q || !out_stall_i;
  // a fire result is held back until the next fire shows it is not the last
  assign step_emit = head_res.fire && pend_valid_q;
  assign shift     = (state_q == ST_STEP) && (!step_emit || out_free);

  always_comb begin
    fin_emit = 1'b0;
    fin_res  = '{event_res: ptq_pkg::EV_NOTFOUND, result_id: '0,
                 live_count: ptq_pkg::LcW'(live_q), last: 1'b1};
    unique case (cmd_q.kind)
      ptq_pkg::KIND_ADD: begin
        fin_emit = 1'b1;
        if (found_q) begin
          fin_res.event_res = ptq_pkg::EV_ADDED;
          fin_res.result_id = cmd_q.id_new;
        end else begin
          fin_res.event_res = ptq_pkg::EV_FULL;
        end
      end
      ptq_pkg::KIND_REMOVE: begin
        fin_emit = 1'b1;
        if (found_q) begin
          fin_res.event_res = ptq_pkg::EV_REMOVED;
          fin_res.result_id = cmd_q.rid;
        end
      end
      ptq_pkg::KIND_TICK: begin
        fin_emit     = pend_valid_q;
        fin_res      = pend_q;
        fin_res.last = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    found_d      = found_q;
    live_d       = live_q;
    idc_d        = idc_q;
    cmd_d        = cmd_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_d        = out_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d.kind   = in_req_i.kind;
          cmd_d.period = (in_req_i.period_ticks == '0) ? ptq_pkg::CntW'(1)
                                                        : in_req_i.period_ticks;
          cmd_d.rpt    = in_req_i.repeat_req;
          cmd_d.rid    = in_req_i.timer_id;
          cmd_d.id_new = id_next;
          found_d      = 1'b0;
          step_d       = '0;
          state_d      = ST_STEP;
        end
      end
      ST_STEP: begin
        if (shift) begin
          found_d = head_res.found;
          live_d  = head_live;
          if (head_res.fire) begin
            pend_valid_d = 1'b1;
            pend_d       = '{event_res: ptq_pkg::EV_FIRED, result_id: head_res.fire_id,
                             live_count: ptq_pkg::LcW'(head_live), last: 1'b0};
          end
          if (step_emit) begin
            out_valid_d = 1'b1;
            out_d       = pend_q;
          end
          step_d = step_q + SW'(1);
          if (step_q == SW'(NUM_SLOTS - 1)) begin
            state_d = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (!fin_emit || out_free) begin
          if (fin_emit) begin
            out_valid_d = 1'b1;
            out_d       = fin_res;
          end
          if (cmd_q.kind == ptq_pkg::KIND_ADD && found_q) begin
            idc_d = cmd_q.id_new;
          end
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      step_q       <= '0;
      found_q      <= 1'b0;
      live_q       <= '0;
      idc_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      step_q       <= step_d;
      found_q      <= found_d;
      live_q       <= live_d;
      idc_q        <= idc_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

`include "periodic_timer_queue_assert.svh"

  `PTQ_ASSERT_IMP(a_live_bound, 1'b1, live_q <= LW'(NUM_SLOTS), "live count above slot count")
  `PTQ_ASSERT_IMP(a_pend_idle, state_q == ST_IDLE, !pend_valid_q, "pending fire left after pass")
  `PTQ_ASSERT_IMP(a_pend_tick, pend_valid_q, cmd_q.kind == ptq_pkg::KIND_TICK, "pending fire on non-tick request")
  `PTQ_ASSERT_NXT(a_step_hold, state_q == ST_STEP && !shift, $stable(step_q) && state_q == ST_STEP, "ring moved while stalled")

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// timer queue testbench: a queue-fed driver sends add, remove, tick and unused-kind
// requests while a clocked monitor checks every result against a timer table
// kept in the bench, under random idling on both sides
// ----------------------------------------------------------------------------

module tb_top;

  localparam int NUM_SLOTS = 16;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int RANDOM_REQS = 145;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  ptq_pkg::in_t in_req_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  ptq_pkg::out_t out_res_o;

  periodic_timer_queue #(
    .NUM_SLOTS(NUM_SLOTS)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_req_i(in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_res_o(out_res_o)
  );

  // timer table as the bench sees it
  logic tmr_live [NUM_SLOTS];
  logic [ptq_pkg::IdW-1:0] tmr_id [NUM_SLOTS];
  logic [ptq_pkg::CntW-1:0] tmr_left [NUM_SLOTS];
  logic [ptq_pkg::CntW-1:0] tmr_period [NUM_SLOTS];
  logic tmr_rpt [NUM_SLOTS];
  logic [ptq_pkg::IdW-1:0] last_id = '0;

  ptq_pkg::in_t pending_reqs [$];
  ptq_pkg::out_t expected_res [$];
  int err_count = 0;
  int n_accepted = 0;
  int n_results = 0;
  logic req_taken_q = 1'b0;
  logic res_taken_q = 1'b0;
  logic hold_rx = 1'b0;
  int tx_idle = 0;
  int rx_idle = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    for (int s = 0; s < NUM_SLOTS; s++) begin
      tmr_live[s] = 1'b0;
    end
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  function automatic logic [ptq_pkg::LcW-1:0] live_timers();
    logic [ptq_pkg::LcW-1:0] n;
    n = '0;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      if (tmr_live[s]) n++;
    end
    return n;
  endfunction

  // no idling for one stretch of twenty requests in every sixty
  function automatic int idle_draw(int seq);
    if ((seq / 20) % 3 == 0) return 0;
    return $urandom_range(0, 13);
  endfunction

  task automatic predict_timer_step(input ptq_pkg::in_t req);
    int hit;
    int n_fired;
    ptq_pkg::out_t res;
    res = '0;
    hit = -1;
    n_fired = 0;
    case (req.kind)
      ptq_pkg::KIND_ADD: begin
        for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
          if (!tmr_live[s]) hit = s;
        end
        res.last = 1'b1;
        if (hit < 0) begin
          res.event_res = ptq_pkg::EV_FULL;
        end else begin
          last_id = last_id + ptq_pkg::IdW'(1);
          if (last_id == '0) last_id = ptq_pkg::IdW'(1);
          tmr_live[hit] = 1'b1;
          tmr_id[hit] = last_id;
          tmr_period[hit] = (req.period_ticks == '0) ? ptq_pkg::CntW'(1) : req.period_ticks;
          tmr_left[hit] = tmr_period[hit];
          tmr_rpt[hit] = req.repeat_req;
          res.event_res = ptq_pkg::EV_ADDED;
          res.result_id = last_id;
        end
        res.live_count = live_timers();
        expected_res.push_back(res);
      end
      ptq_pkg::KIND_REMOVE: begin
        for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
          if (tmr_live[s] && tmr_id[s] == req.timer_id) hit = s;
        end
        res.last = 1'b1;
        if (hit < 0) begin
          res.event_res = ptq_pkg::EV_NOTFOUND;
        end else begin
          tmr_live[hit] = 1'b0;
          res.event_res = ptq_pkg::EV_REMOVED;
          res.result_id = req.timer_id;
        end
        res.live_count = live_timers();
        expected_res.push_back(res);
      end
      ptq_pkg::KIND_TICK: begin
        for (int s = 0; s < NUM_SLOTS; s++) begin
          if (tmr_live[s]) begin
            tmr_left[s] = tmr_left[s] - ptq_pkg::CntW'(1);
            if (tmr_left[s] == '0) begin
              if (tmr_rpt[s]) tmr_left[s] = tmr_period[s];
              else tmr_live[s] = 1'b0;
              res.event_res = ptq_pkg::EV_FIRED;
              res.result_id = tmr_id[s];
              res.live_count = live_timers();
              res.last = 1'b0;
              expected_res.push_back(res);
              n_fired++;
            end
          end
        end
        if (n_fired > 0) begin
          res = expected_res.pop_back();
          res.last = 1'b1;
          expected_res.push_back(res);
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_count++;
    if (err_count <= 40) begin
      $display("%0t mismatch: %s got %0d expected %0d", $time, what, got, want);
    end
  endtask

  // driver: one request at a time from the pending queue
  always @(negedge clk_i) begin : drv
    logic nxt_valid;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_req_i <= '0;
      tx_idle = 0;
    end else begin
      nxt_valid = in_valid_i;
      if (req_taken_q) begin
        predict_timer_step(in_req_i);
        n_accepted++;
        nxt_valid = 1'b0;
        tx_idle = idle_draw(n_accepted);
      end
      if (!nxt_valid) begin
        if (tx_idle != 0) begin
          tx_idle--;
        end else if (pending_reqs.size() != 0) begin
          in_req_i <= pending_reqs.pop_front();
          nxt_valid = 1'b1;
        end
      end
      in_valid_i <= nxt_valid;
    end
  end

  // receiver stall
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      rx_idle = 0;
    end else begin
      if (res_taken_q) rx_idle = idle_draw(n_results);
      if (hold_rx) begin
        out_stall_i <= 1'b1;
      end else if (rx_idle != 0) begin
        rx_idle--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin : mon
    ptq_pkg::out_t want;
    req_taken_q <= rst_ni && in_valid_i && !in_stall_o;
    res_taken_q <= rst_ni && out_valid_o && !out_stall_i;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results++;
      if (expected_res.size() == 0) begin
        report_mismatch("result with nothing pending, event",
                        32'(out_res_o.event_res), 32'd0);
      end else begin
        want = expected_res.pop_front();
        if (out_res_o.event_res !== want.event_res)
          report_mismatch("event_res", 32'(out_res_o.event_res), 32'(want.event_res));
        if (out_res_o.result_id !== want.result_id)
          report_mismatch("result_id", 32'(out_res_o.result_id), 32'(want.result_id));
        if (out_res_o.live_count !== want.live_count)
          report_mismatch("live_count", 32'(out_res_o.live_count), 32'(want.live_count));
        if (out_res_o.last !== want.last)
          report_mismatch("last", 32'(out_res_o.last), 32'(want.last));
      end
    end
  end

  // long receiver hold-off so the block backs up into its request side
  initial begin
    while (n_accepted < 70) @(posedge clk_i);
    hold_rx = 1'b1;
    repeat (400) @(posedge clk_i);
    hold_rx = 1'b0;
  end

  function automatic ptq_pkg::in_t mk_req(logic [1:0] kind, logic [ptq_pkg::CntW-1:0] per,
                                          logic rpt, logic [ptq_pkg::IdW-1:0] id);
    ptq_pkg::in_t r;
    r.kind = kind;
    r.period_ticks = per;
    r.repeat_req = rpt;
    r.timer_id = id;
    return r;
  endfunction

  task automatic queue_req(input ptq_pkg::in_t r);
    while (pending_reqs.size() >= 2) @(posedge clk_i);
    pending_reqs.push_back(r);
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_valid_i || expected_res.size() != 0)
      @(posedge clk_i);
  endtask

  initial begin : stim
    int n_real;
    int pick;
    ptq_pkg::in_t req;
    logic [ptq_pkg::IdW-1:0] live_ids [$];
    @(posedge rst_ni);

    // zero period, one-shot and periodic, then expiry order and reload
    queue_req(mk_req(ptq_pkg::KIND_ADD, 32'd0, 1'b0, '0));
    queue_req(mk_req(ptq_pkg::KIND_ADD, 32'd0, 1'b1, '0));
    queue_req(mk_req(ptq_pkg::KIND_ADD, 32'd2, 1'b1, '0));
    queue_req(mk_req(ptq_pkg::KIND_TICK, '0, 1'b0, '0));
    queue_req(mk_req(ptq_pkg::KIND_TICK, '0, 1'b0, '0));
    queue_req(mk_req(KIND_UNUSED, '1, 1'b1, '1));
    queue_req(mk_req(ptq_pkg::KIND_REMOVE, '0, 1'b0, 31'd2));
    queue_req(mk_req(ptq_pkg::KIND_REMOVE, '1, 1'b1, 31'd0));
    queue_req(mk_req(ptq_pkg::KIND_REMOVE, '0, 1'b0, '1));
    queue_req(mk_req(ptq_pkg::KIND_REMOVE, '0, 1'b0, 31'd3));
    // quiet tick on an empty table
    queue_req(mk_req(ptq_pkg::KIND_TICK, '1, 1'b1, '1));
    // fill the table, overflow it, then expire all slots on one tick
    for (int k = 0; k < NUM_SLOTS; k++) begin
      queue_req(mk_req(ptq_pkg::KIND_ADD, 32'd1, 1'b0, '0));
    end
    queue_req(mk_req(ptq_pkg::KIND_ADD, 32'd5, 1'b1, '0));
    queue_req(mk_req(ptq_pkg::KIND_TICK, '0, 1'b0, '0));
    queue_req(mk_req(ptq_pkg::KIND_ADD, '1, 1'b1, '0));
    wait_drained();

    n_real = 0;
    while (n_real < RANDOM_REQS) begin
      // sender pause until the block has drained
      if (n_real == 110) wait_drained();
      req.kind = ptq_pkg::KIND_TICK;
      req.period_ticks = $urandom();
      req.repeat_req = 1'($urandom_range(0, 1));
      req.timer_id = ptq_pkg::IdW'($urandom());
      pick = $urandom_range(0, 99);
      if (pick < 38) begin
        req.kind = ptq_pkg::KIND_ADD;
        pick = $urandom_range(0, 9);
        if (pick < 7) req.period_ticks = $urandom_range(0, 12);
        else if (pick < 9) req.period_ticks = $urandom_range(13, 60);
      end else if (pick < 60) begin
        req.kind = ptq_pkg::KIND_REMOVE;
        live_ids.delete();
        for (int s = 0; s < NUM_SLOTS; s++) begin
          if (tmr_live[s]) live_ids.push_back(tmr_id[s]);
        end
        if (live_ids.size() != 0 && $urandom_range(0, 4) != 0)
          req.timer_id = live_ids[$urandom_range(0, live_ids.size() - 1)];
        else if ($urandom_range(0, 3) == 0)
          req.timer_id = '0;
      end else if (pick >= 95) begin
        req.kind = KIND_UNUSED;
      end
      if (req.kind != KIND_UNUSED) n_real++;
      queue_req(req);
    end

    wait_drained();
    repeat (4 * NUM_SLOTS + 40) @(posedge clk_i);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
